// ----- rtl/rmm_pkg.sv -----
package rmm_pkg;

  // field widths
  localparam int MASS_W     = 32;
  localparam int TOL_W      = 16;
  localparam int THR_W      = 25;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = 5;
  localparam int TBL_W      = 24;
  localparam int SUM_W      = TBL_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = THR_W;

  // table sizes and result cap
  localparam int MAX_MATCHES   = 64;
  localparam int RESIDUE_COUNT = 21;
  localparam int SINGLE_COUNT  = 19;
  localparam int FMET_INDEX    = 18;
  localparam int CNT_W         = $clog2(MAX_MATCHES + 1);

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SINGLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAIR   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_THR  = 2'd1;

  // reset values
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd32768;
  localparam logic [THR_W-1:0] THR_RESET = 25'd7208960;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic single_step;
    logic pair_init;
    logic pair_step;
    logic flush;
  } rmm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic single_end;
    logic pair_end;
    logic above_thr;
    logic slot_free;
  } rmm_stat_t;

  // single-residue table, Q8.16
  function automatic logic [TBL_W-1:0] single_mass(input logic [IDX_W-1:0] idx);
    logic [TBL_W-1:0] m;
    case (idx)
      5'd0:    m = 24'd3736958;
      5'd1:    m = 24'd4655488;
      5'd2:    m = 24'd5703731;
      5'd3:    m = 24'd6360450;
      5'd4:    m = 24'd6492547;
      5'd5:    m = 24'd6622261;
      5'd6:    m = 24'd6750810;
      5'd7:    m = 24'd7411077;
      5'd8:    m = 24'd7473917;
      5'd9:    m = 24'd7538406;
      5'd10:   m = 24'd8392447;
      5'd11:   m = 24'd8456935;
      5'd12:   m = 24'd8587870;
      5'd13:   m = 24'd8982293;
      5'd14:   m = 24'd9638275;
      5'd15:   m = 24'd10230242;
      5'd16:   m = 24'd10686518;
      5'd17:   m = 24'd12194894;
      5'd18:   m = 24'd10423539;
      default: m = '0;
    endcase
    return m;
  endfunction

  // residue table used for pairs, Q8.16
  function automatic logic [TBL_W-1:0] residue_mass(input logic [IDX_W-1:0] idx);
    logic [TBL_W-1:0] m;
    case (idx)
      5'd0:    m = 24'd3736958;
      5'd1:    m = 24'd4655488;
      5'd2:    m = 24'd5703731;
      5'd3:    m = 24'd6360450;
      5'd4:    m = 24'd6492547;
      5'd5:    m = 24'd6622261;
      5'd6:    m = 24'd6750810;
      5'd7:    m = 24'd7411077;
      5'd8:    m = 24'd7411077;
      5'd9:    m = 24'd7473917;
      5'd10:   m = 24'd7538406;
      5'd11:   m = 24'd8392447;
      5'd12:   m = 24'd8394831;
      5'd13:   m = 24'd8456935;
      5'd14:   m = 24'd8587870;
      5'd15:   m = 24'd8982293;
      5'd16:   m = 24'd9638275;
      5'd17:   m = 24'd10230242;
      5'd18:   m = 24'd10423539;
      5'd19:   m = 24'd10686518;
      5'd20:   m = 24'd12194894;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/rmm_ifs.sv -----
// input channel: one mass per beat
interface rmm_in_if import rmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASS_W-1:0] mass;
  modport source (output valid, output mass, input ready);
  modport sink (input valid, input mass, output ready);
endinterface

// result channel: one result per beat
interface rmm_out_if import rmm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  first_index;
  logic [IDX_W-1:0]  second_index;
  logic              truncated;
  logic              last;
  modport source (output valid, output kind, output first_index, output second_index,
                  output truncated, output last, input ready);
  modport sink (input valid, input kind, input first_index, input second_index,
                input truncated, input last, output ready);
endinterface

// register write channel
interface rmm_cfg_if import rmm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rmm_ctrl.sv -----
module rmm_ctrl import rmm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rmm_stat_t stat,
  output rmm_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SINGLE = 2'd1;
  localparam logic [1:0] S_PAIR   = 2'd2;
  localparam logic [1:0] S_FLUSH  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // sequencing of one mass
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SINGLE;
        end
      end
      S_SINGLE: begin
        cmd.single_step = 1'b1;
        if (stat.single_end) begin
          if (stat.above_thr) begin
            cmd.pair_init = 1'b1;
            state_nxt     = S_PAIR;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_PAIR: begin
        if (stat.slot_free) begin
          cmd.pair_step = 1'b1;
          if (stat.pair_end) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (stat.slot_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/rmm_dp.sv -----
module rmm_dp import rmm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rmm_cmd_t              cmd,
  output rmm_stat_t             stat,
  input  logic [MASS_W-1:0]     in_mass,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_kind,
  output logic [IDX_W-1:0]      out_first_index,
  output logic [IDX_W-1:0]      out_second_index,
  output logic                  out_truncated,
  output logic                  out_last
);

  localparam logic [IDX_W-1:0] LAST_SINGLE  = IDX_W'(SINGLE_COUNT - 1);
  localparam logic [IDX_W-1:0] LAST_RESIDUE = IDX_W'(RESIDUE_COUNT - 1);
  localparam logic [IDX_W-1:0] FMET_IDX     = IDX_W'(FMET_INDEX);
  localparam logic [CNT_W-1:0] CAP          = CNT_W'(MAX_MATCHES);

  logic [TOL_W-1:0]  tol_r;
  logic [THR_W-1:0]  thr_r;
  logic [MASS_W-1:0] mass_r;
  logic [IDX_W-1:0]  i1_r, i1_nxt;
  logic [IDX_W-1:0]  i2_r, i2_nxt;
  logic              pend_valid_r;
  logic [KIND_W-1:0] pend_kind_r;
  logic [IDX_W-1:0]  pend_a_r;
  logic [IDX_W-1:0]  pend_b_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              drop_r;
  logic              ov_r;
  logic [KIND_W-1:0] okind_r;
  logic [IDX_W-1:0]  ofirst_r;
  logic [IDX_W-1:0]  osecond_r;
  logic              otrunc_r;
  logic              olast_r;

  logic [SUM_W-1:0]  pair_sum;
  logic              single_hit;
  logic              pair_hit;
  logic              pair_rec;
  logic              push_pend;
  logic              slot_free;

  // open window test: centre - tol < mass < centre + tol
  function automatic logic in_win(input logic [MASS_W-1:0] m,
                                  input logic [SUM_W-1:0]  c,
                                  input logic [TOL_W-1:0]  t);
    logic [MASS_W:0] m_lo;
    logic [MASS_W:0] c_hi;
    m_lo = {1'b0, m} + {{(MASS_W+1-TOL_W){1'b0}}, t};
    c_hi = {{(MASS_W+1-SUM_W){1'b0}}, c} + {{(MASS_W+1-TOL_W){1'b0}}, t};
    return (m_lo > {{(MASS_W+1-SUM_W){1'b0}}, c}) && ({1'b0, m} < c_hi);
  endfunction

  // match evaluation for the current walk position
  assign pair_sum   = {1'b0, residue_mass(i1_r)} + {1'b0, residue_mass(i2_r)};
  assign single_hit = in_win(mass_r, {1'b0, single_mass(i1_r)}, tol_r);
  assign pair_hit   = in_win(mass_r, pair_sum, tol_r) &&
                      !((i1_r == FMET_IDX) && (i2_r == FMET_IDX));
  assign pair_rec   = cmd.pair_step && pair_hit && (cnt_r < CAP);
  assign push_pend  = pair_rec && pend_valid_r;
  assign slot_free  = !ov_r || out_ready;

  assign stat.single_end = (i1_r == LAST_SINGLE);
  assign stat.pair_end   = (i1_r == LAST_RESIDUE) && (i2_r == LAST_RESIDUE);
  assign stat.above_thr  = (mass_r > {{(MASS_W-THR_W){1'b0}}, thr_r});
  assign stat.slot_free  = slot_free;

  // walk indices
  always_comb begin
    i1_nxt = i1_r;
    i2_nxt = i2_r;
    if (cmd.load || cmd.pair_init) begin
      i1_nxt = '0;
      i2_nxt = '0;
    end else if (cmd.single_step) begin
      i1_nxt = i1_r + 1'b1;
    end else if (cmd.pair_step) begin
      if (i2_r == LAST_RESIDUE) begin
        i1_nxt = i1_r + 1'b1;
        i2_nxt = i1_r + 1'b1;
      end else begin
        i2_nxt = i2_r + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    i1_r <= i1_nxt;
    i2_r <= i2_nxt;
    if (cmd.load) begin
      mass_r <= in_mass;
    end
    if (cmd.single_step && single_hit) begin
      pend_kind_r <= KIND_SINGLE;
      pend_a_r    <= i1_r;
      pend_b_r    <= '0;
    end else if (pair_rec) begin
      pend_kind_r <= KIND_PAIR;
      pend_a_r    <= i1_r;
      pend_b_r    <= i2_r;
    end
    // result register load
    if (push_pend) begin
      okind_r   <= pend_kind_r;
      ofirst_r  <= pend_a_r;
      osecond_r <= pend_b_r;
      otrunc_r  <= 1'b0;
      olast_r   <= 1'b0;
    end else if (cmd.flush) begin
      okind_r   <= pend_valid_r ? pend_kind_r : KIND_NONE;
      ofirst_r  <= pend_valid_r ? pend_a_r : '0;
      osecond_r <= pend_valid_r ? pend_b_r : '0;
      otrunc_r  <= drop_r;
      olast_r   <= 1'b1;
    end
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r        <= TOL_RESET;
      thr_r        <= THR_RESET;
      pend_valid_r <= 1'b0;
      cnt_r        <= '0;
      drop_r       <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == REG_TOLERANCE)) begin
        tol_r <= cfg_data[TOL_W-1:0];
      end
      if (cfg_valid && (cfg_index == REG_PAIR_THR)) begin
        thr_r <= cfg_data[THR_W-1:0];
      end
      if (cmd.load) begin
        pend_valid_r <= 1'b0;
        cnt_r        <= '0;
        drop_r       <= 1'b0;
      end else if (cmd.single_step && single_hit) begin
        pend_valid_r <= 1'b1;
        cnt_r        <= CNT_W'(1);
      end else if (pair_rec) begin
        pend_valid_r <= 1'b1;
        cnt_r        <= cnt_r + 1'b1;
      end else if (cmd.pair_step && pair_hit) begin
        drop_r <= 1'b1;
      end
      if (push_pend || cmd.flush) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid        = ov_r;
  assign out_kind         = okind_r;
  assign out_first_index  = ofirst_r;
  assign out_second_index = osecond_r;
  assign out_truncated    = otrunc_r;
  assign out_last         = olast_r;

endmodule

// ----- rtl/residue_mass_matcher_unit.sv -----
// channel   dir  beat contents
// in_ch     in   mass (Q16.16)
// out_ch    out  kind, first_index, second_index, truncated, last
// cfg_ch    in   index, data (0 tolerance, 1 pair_threshold)
//
// one mass at a time: an accept step, a walk of the single table, then a walk
// of the residue pairs when mass is above pair_threshold, then a final step
// that emits the last beat; the walk tests one entry or one pair a cycle
// the pair walk pauses while a result sits unaccepted in the output register
// rst_n is synchronous: registers return to 0.5 and 110.0, channels go idle
// register writes are taken in any cycle (cfg_ch.ready is always high)
module residue_mass_matcher_unit import rmm_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  rmm_in_if.sink    in_ch,
  rmm_out_if.source out_ch,
  rmm_cfg_if.sink   cfg_ch
);

  rmm_cmd_t  cmd;
  rmm_stat_t stat;
  logic      in_ready;

  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  // sequencer
  rmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tables, comparator and result registers
  rmm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_mass          (in_ch.mass),
    .cfg_valid        (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_kind         (out_ch.kind),
    .out_first_index  (out_ch.first_index),
    .out_second_index (out_ch.second_index),
    .out_truncated    (out_ch.truncated),
    .out_last         (out_ch.last)
  );

endmodule

// ----- rtl/rmm_chk.sv -----
module rmm_chk import rmm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [IDX_W-1:0]  out_first_index,
  input logic [IDX_W-1:0]  out_second_index,
  input logic              out_truncated,
  input logic              out_last
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // one mass at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // truncation is only flagged on the final beat
  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_last)
    else $error("truncated set on a non-final beat");

  // no-match result is alone and carries zero indices
  a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_NONE) |->
      out_last && (out_first_index == '0) && (out_second_index == '0))
    else $error("malformed no-match beat");

  // second index only on pair matches
  a_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_PAIR) |-> (out_second_index == '0))
    else $error("second index set on a non-pair beat");

endmodule

bind residue_mass_matcher_unit rmm_chk u_rmm_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_kind         (out_ch.kind),
  .out_first_index  (out_ch.first_index),
  .out_second_index (out_ch.second_index),
  .out_truncated    (out_ch.truncated),
  .out_last         (out_ch.last)
);
